[hdl/sha256_byte_hasher_top_assert.svh]
// Assertion macros for the SHA-256 byte hasher RTL (used by shabh_ctrl).
// Users need clk and rst_n in scope; define NO_ASSERTIONS to compile them out.
`ifndef SHA256_BYTE_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_HASHER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 hasher assertion failed");

// Next-cycle implication.
`define SHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 hasher assertion failed");

`else

`define SHA_ASSERT_IMP(label, ante, cons)
`define SHA_ASSERT_NXT(label, ante, cons)

`endif

`endif

[hdl/shabh_pkg.sv]
// Package for the SHA-256 byte hasher: beat types, control structs, state encoding,
// round constants and initial hash words. No dependencies.
`default_nettype none

package shabh_pkg;

  localparam int WORD_W     = 32;
  localparam int BLK_WORDS  = 16;
  localparam int HASH_WORDS = 8;
  localparam int ROUNDS     = 64;
  localparam int MSG_AW     = 4;
  localparam int HASH_AW    = 3;
  localparam int SCHED_W    = 7;
  localparam int CNT_W      = 6;
  localparam int FILL_W     = 6;
  localparam int LEN_W      = 61;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Message word positions used by the padding sequencer.
  localparam logic [MSG_AW-1:0] PAD_LAST_WORD = MSG_AW'(BLK_WORDS - 3);
  localparam logic [MSG_AW-1:0] LEN_HI_ADDR   = MSG_AW'(BLK_WORDS - 2);
  localparam logic [MSG_AW-1:0] LEN_LO_ADDR   = MSG_AW'(BLK_WORDS - 1);
  // Offset from W[t-16] to W[t-7] in the circular schedule buffer.
  localparam logic [MSG_AW-1:0] TAP7_OFS      = MSG_AW'(BLK_WORDS - 7);

  localparam logic [CNT_W-1:0] CNT_XFER_END = CNT_W'(HASH_WORDS);
  localparam logic [CNT_W-1:0] CNT_ROUND_END = CNT_W'(ROUNDS - 1);
  localparam logic [HASH_AW-1:0] DIG_LAST   = HASH_AW'(HASH_WORDS - 1);

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       final_item;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  digest_word;
    logic [HASH_AW-1:0] word_index;
    logic               last_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DIG_RD,
    ST_DIG_WR
  } state_t;

  typedef struct packed {
    logic               var_shift;
    logic               round_en;
    logic               sched_en;
    logic               hash_iv;
    logic [HASH_AW-1:0] var_idx;
    logic [SCHED_W-1:0] sched_idx;
  } core_ctl_t;

  typedef struct packed {
    logic              we;
    logic [MSG_AW-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [MSG_AW-1:0] raddr_a;
    logic [MSG_AW-1:0] raddr_b;
  } msg_req_t;

  typedef struct packed {
    logic               we;
    logic [HASH_AW-1:0] waddr;
    logic               re0;
    logic [HASH_AW-1:0] raddr0;
    logic               re1;
    logic [HASH_AW-1:0] raddr1;
  } hash_req_t;

  localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

[hdl/shabh_ram.sv]
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
`default_nettype none

module shabh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[hdl/shabh_core.sv]
// Compression datapath: working variables a..h, message schedule step and hash update add.
// Depends on shabh_pkg; reads both RAMs through the top level.
`default_nettype none

module shabh_core import shabh_pkg::*; (
  input  logic              clk,
  input  core_ctl_t         ctl,
  input  logic [WORD_W-1:0] hash_rd,
  input  logic [WORD_W-1:0] msg_rd_a,
  input  logic [WORD_W-1:0] msg_rd_b,
  output logic [WORD_W-1:0] sched_word,
  output logic [WORD_W-1:0] hash_sum
);

  logic [WORD_W-1:0] v_r   [HASH_WORDS];
  logic [WORD_W-1:0] v_nxt [HASH_WORDS];
  logic [WORD_W-1:0] wk_r;
  logic [WORD_W-1:0] w16_r;
  logic [WORD_W-1:0] w1_r;
  logic [WORD_W-1:0] w2_r;
  logic [WORD_W-1:0] hash_val;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;

  function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_s0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] small_s1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Until the first block of a message is folded in, the hash store reads as the IV.
  assign hash_val = ctl.hash_iv ? INIT_HASH[ctl.var_idx] : hash_rd;
  assign hash_sum = hash_val + v_r[ctl.var_idx];

  // Port A carries W[t-15], port B carries W[t-7] (or W[t] itself in the first 16 steps).
  assign sched_word = (ctl.sched_idx < SCHED_W'(BLK_WORDS)) ? msg_rd_b :
                      w16_r + small_s0(msg_rd_a) + msg_rd_b + small_s1(w2_r);

  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + wk_r;
  assign t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    v_nxt = v_r;
    if (ctl.var_shift) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        v_nxt[i] = v_r[i+1];
      end
      v_nxt[HASH_WORDS-1] = hash_val;
    end else if (ctl.round_en) begin
      v_nxt[0] = t1 + t2;
      v_nxt[1] = v_r[0];
      v_nxt[2] = v_r[1];
      v_nxt[3] = v_r[2];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[5] = v_r[4];
      v_nxt[6] = v_r[5];
      v_nxt[7] = v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (ctl.sched_en) begin
      wk_r  <= sched_word + ROUND_K[ctl.sched_idx[CNT_W-1:0]];
      w16_r <= msg_rd_a;
      w1_r  <= sched_word;
      w2_r  <= w1_r;
    end
  end

endmodule

`default_nettype wire

[hdl/shabh_ctrl.sv]
// Sequencer: byte packing, padding, compression phases, RAM addressing and digest output.
// Depends on shabh_pkg and the assertion macro header.
`default_nettype none

`include "sha256_byte_hasher_top_assert.svh"

module shabh_ctrl import shabh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  output core_ctl_t         ctl,
  input  logic [WORD_W-1:0] sched_word,
  output msg_req_t          msg_req,
  output hash_req_t         hash_req,
  input  logic [WORD_W-1:0] hash_rd1
);

  state_t              st_r, st_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [WORD_W-1:0]   acc_r, acc_nxt;
  logic [MSG_AW-1:0]   widx_r, widx_nxt;
  logic                fin_r, fin_nxt;
  logic                padded_r, padded_nxt;
  logic                len_done_r, len_done_nxt;
  logic                iv_r, iv_nxt;
  logic [HASH_AW-1:0]  dig_idx_r, dig_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r;

  logic                in_take;
  logic                out_load;
  logic [WORD_W-1:0]   acc_ins;
  logic [WORD_W-1:0]   pad_word;
  logic [FILL_W-1:0]   fill_inc;
  logic [CNT_W-1:0]    cnt_m1;
  logic [SCHED_W-1:0]  rd_tgt;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_load  = (st_r == ST_DIG_WR) && (!out_valid_r || out_ready);
  assign fill_inc  = fill_r + FILL_W'(1);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (fill_r[1:0])
      2'd0: acc_ins = {in_data.message_byte, acc_r[23:0]};
      2'd1: acc_ins = {acc_r[31:24], in_data.message_byte, acc_r[15:0]};
      2'd2: acc_ins = {acc_r[31:16], in_data.message_byte, acc_r[7:0]};
      2'd3: acc_ins = {acc_r[31:8], in_data.message_byte};
    endcase
  end

  // Bytes already held stay, the marker byte follows them, the rest of the word is zero.
  always_comb begin
    unique case (fill_r[1:0])
      2'd0: pad_word = {PAD_BYTE, 24'h0};
      2'd1: pad_word = {acc_r[31:24], PAD_BYTE, 16'h0};
      2'd2: pad_word = {acc_r[31:16], PAD_BYTE, 8'h0};
      2'd3: pad_word = {acc_r[31:8], PAD_BYTE};
    endcase
  end

  // Next state and register updates.
  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    widx_nxt     = widx_r;
    fin_nxt      = fin_r;
    padded_nxt   = padded_r;
    len_done_nxt = len_done_r;
    iv_nxt       = iv_r;
    dig_idx_nxt  = dig_idx_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_data.byte_present) begin
            acc_nxt  = acc_ins;
            fill_nxt = fill_inc;
            len_nxt  = len_r + LEN_W'(1);
            if (&fill_r) begin
              st_nxt  = ST_LOAD;
              cnt_nxt = '0;
              fin_nxt = in_data.final_item;
            end else if (in_data.final_item) begin
              st_nxt   = ST_PAD;
              widx_nxt = fill_inc[FILL_W-1:2];
              fin_nxt  = 1'b1;
            end
          end else if (in_data.final_item) begin
            st_nxt   = ST_PAD;
            widx_nxt = fill_r[FILL_W-1:2];
            fin_nxt  = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_XFER_END) begin
          st_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        st_nxt  = ST_ROUND;
        cnt_nxt = '0;
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_ROUND_END) begin
          st_nxt  = ST_ADD;
          cnt_nxt = '0;
        end
      end
      ST_ADD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_XFER_END) begin
          cnt_nxt = '0;
          iv_nxt  = 1'b0;
          priority if (len_done_r) begin
            st_nxt      = ST_DIG_RD;
            dig_idx_nxt = '0;
          end else if (fin_r) begin
            st_nxt   = ST_PAD;
            widx_nxt = padded_r ? '0 : fill_r[FILL_W-1:2];
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        padded_nxt = 1'b1;
        widx_nxt   = widx_r + MSG_AW'(1);
        if (widx_r == LEN_LO_ADDR) begin
          // Marker landed too late for the length: finish this block and pad another.
          st_nxt  = ST_LOAD;
          cnt_nxt = '0;
        end else if (widx_r == PAD_LAST_WORD) begin
          st_nxt = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        st_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        st_nxt       = ST_LOAD;
        cnt_nxt      = '0;
        len_done_nxt = 1'b1;
      end
      ST_DIG_RD: begin
        st_nxt = ST_DIG_WR;
      end
      ST_DIG_WR: begin
        if (out_load) begin
          if (dig_idx_r == DIG_LAST) begin
            st_nxt       = ST_IDLE;
            fin_nxt      = 1'b0;
            padded_nxt   = 1'b0;
            len_done_nxt = 1'b0;
            iv_nxt       = 1'b1;
            fill_nxt     = '0;
            len_nxt      = '0;
          end else begin
            dig_idx_nxt = dig_idx_r + HASH_AW'(1);
            st_nxt      = ST_DIG_RD;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM requests and datapath control.
  always_comb begin
    msg_req       = '0;
    hash_req      = '0;
    ctl           = '0;
    ctl.hash_iv   = iv_r;
    rd_tgt        = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_take && in_data.byte_present && (fill_r[1:0] == 2'd3)) begin
          msg_req.we    = 1'b1;
          msg_req.waddr = fill_r[FILL_W-1:2];
          msg_req.wdata = acc_ins;
        end
      end
      ST_LOAD: begin
        if (cnt_r != CNT_XFER_END) begin
          hash_req.re0    = 1'b1;
          hash_req.raddr0 = cnt_r[HASH_AW-1:0];
        end else begin
          msg_req.re = 1'b1;
        end
        if (cnt_r != '0) begin
          ctl.var_shift = 1'b1;
          ctl.var_idx   = cnt_m1[HASH_AW-1:0];
        end
      end
      ST_PREP: begin
        ctl.sched_en = 1'b1;
        msg_req.re   = 1'b1;
        rd_tgt       = SCHED_W'(1);
      end
      ST_ROUND: begin
        ctl.round_en  = 1'b1;
        ctl.sched_en  = 1'b1;
        ctl.sched_idx = {1'b0, cnt_r} + SCHED_W'(1);
        msg_req.re    = 1'b1;
        rd_tgt        = {1'b0, cnt_r} + SCHED_W'(2);
        if ((ctl.sched_idx >= SCHED_W'(BLK_WORDS)) && (ctl.sched_idx < SCHED_W'(ROUNDS))) begin
          msg_req.we    = 1'b1;
          msg_req.waddr = ctl.sched_idx[MSG_AW-1:0];
          msg_req.wdata = sched_word;
        end
      end
      ST_ADD: begin
        if (cnt_r != CNT_XFER_END) begin
          hash_req.re0    = 1'b1;
          hash_req.raddr0 = cnt_r[HASH_AW-1:0];
        end
        if (cnt_r != '0) begin
          hash_req.we    = 1'b1;
          hash_req.waddr = cnt_m1[HASH_AW-1:0];
          ctl.var_idx    = cnt_m1[HASH_AW-1:0];
        end
      end
      ST_PAD: begin
        msg_req.we    = 1'b1;
        msg_req.waddr = widx_r;
        msg_req.wdata = padded_r ? '0 : pad_word;
      end
      ST_LEN_HI: begin
        msg_req.we    = 1'b1;
        msg_req.waddr = LEN_HI_ADDR;
        msg_req.wdata = len_r[LEN_W-1:LEN_W-WORD_W];
      end
      ST_LEN_LO: begin
        msg_req.we    = 1'b1;
        msg_req.waddr = LEN_LO_ADDR;
        msg_req.wdata = {len_r[LEN_W-WORD_W-1:0], 3'b000};
      end
      ST_DIG_RD: begin
        hash_req.re1    = 1'b1;
        hash_req.raddr1 = dig_idx_r;
      end
      ST_DIG_WR: begin
      end
      default: begin
      end
    endcase
    // Prefetch for schedule step rd_tgt: W[t-15] on port A, W[t] or W[t-7] on port B.
    msg_req.raddr_a = rd_tgt[MSG_AW-1:0] + MSG_AW'(1);
    msg_req.raddr_b = (rd_tgt < SCHED_W'(BLK_WORDS)) ? rd_tgt[MSG_AW-1:0] :
                      rd_tgt[MSG_AW-1:0] + TAP7_OFS;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      len_r       <= '0;
      widx_r      <= '0;
      fin_r       <= 1'b0;
      padded_r    <= 1'b0;
      len_done_r  <= 1'b0;
      iv_r        <= 1'b1;
      dig_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      widx_r      <= widx_nxt;
      fin_r       <= fin_nxt;
      padded_r    <= padded_nxt;
      len_done_r  <= len_done_nxt;
      iv_r        <= iv_nxt;
      dig_idx_r   <= dig_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (out_load) begin
      out_r <= '{digest_word: hash_rd1, word_index: dig_idx_r,
                 last_word: (dig_idx_r == DIG_LAST)};
    end
  end

  `SHA_ASSERT_IMP(a_sched_wr_range, (st_r == ST_ROUND) && msg_req.we, ctl.sched_idx >= SCHED_W'(BLK_WORDS))
  `SHA_ASSERT_NXT(a_digest_restart, out_load && (dig_idx_r == DIG_LAST), iv_r && (fill_r == '0) && (len_r == '0))
  `SHA_ASSERT_NXT(a_add_clears_iv, (st_r == ST_ADD) && (cnt_r == CNT_XFER_END), !iv_r)
  `SHA_ASSERT_NXT(a_busy_mid_digest, out_valid && out_ready && (out_data.word_index != DIG_LAST) && (out_data.word_index != DIG_LAST - HASH_AW'(1)), !in_ready)

endmodule

`default_nettype wire

[hdl/sha256_byte_hasher_top.sv]
// SHA-256 byte hasher top level: message RAM, hash RAM, compression datapath, sequencer.
// Depends on shabh_pkg, shabh_ram, shabh_core and shabh_ctrl.
// Usage:
//   Input beats (in_valid/in_ready) carry one message byte, a byte-present flag and a
//   final flag. A beat with byte_present low and final_item low is a no-op; one with
//   final_item set ends the message (with or without a byte).
//   Output beats (out_valid/out_ready) carry the eight digest words, index 0 first,
//   last_word set on index 7.
// Timing:
//   Bytes are taken only while the sequencer is idle. Every 64th byte starts a
//   compression: loading a..h from the hash RAM, 1 schedule prefetch, 64 rounds at
//   one per cycle and adding back into the hash RAM. A final beat costs 3 to 16
//   padding writes and one compression. If its byte fills the block, or the marker
//   leaves no room for the length (1 or 2 more writes), another compression comes
//   first. Each digest word is then read from the hash RAM and loaded into the output
//   register once it is free. in_ready is high only between blocks; the last digest word
//   may still wait in the output register while the next message's bytes are taken.
// Reset:
//   rst_n (synchronous, active low) returns to the initial hash value with an empty
//   message and drops out_valid. A stalled out_ready simply holds the digest sequence.
`default_nettype none

module sha256_byte_hasher_top import shabh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  core_ctl_t         ctl;
  msg_req_t          msg_req;
  hash_req_t         hash_req;
  logic [WORD_W-1:0] msg_rd_a;
  logic [WORD_W-1:0] msg_rd_b;
  logic [WORD_W-1:0] hash_rd0;
  logic [WORD_W-1:0] hash_rd1;
  logic [WORD_W-1:0] sched_word;
  logic [WORD_W-1:0] hash_sum;

  shabh_ram #(
    .WIDTH(WORD_W),
    .DEPTH(BLK_WORDS)
  ) u_msg_ram (
    .clk     (clk),
    .we      (msg_req.we),
    .waddr   (msg_req.waddr),
    .wdata   (msg_req.wdata),
    .re_a    (msg_req.re),
    .raddr_a (msg_req.raddr_a),
    .rdata_a (msg_rd_a),
    .re_b    (msg_req.re),
    .raddr_b (msg_req.raddr_b),
    .rdata_b (msg_rd_b)
  );

  shabh_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HASH_WORDS)
  ) u_hash_ram (
    .clk     (clk),
    .we      (hash_req.we),
    .waddr   (hash_req.waddr),
    .wdata   (hash_sum),
    .re_a    (hash_req.re0),
    .raddr_a (hash_req.raddr0),
    .rdata_a (hash_rd0),
    .re_b    (hash_req.re1),
    .raddr_b (hash_req.raddr1),
    .rdata_b (hash_rd1)
  );

  shabh_core u_core (
    .clk        (clk),
    .ctl        (ctl),
    .hash_rd    (hash_rd0),
    .msg_rd_a   (msg_rd_a),
    .msg_rd_b   (msg_rd_b),
    .sched_word (sched_word),
    .hash_sum   (hash_sum)
  );

  shabh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .ctl        (ctl),
    .sched_word (sched_word),
    .msg_req    (msg_req),
    .hash_req   (hash_req),
    .hash_rd1   (hash_rd1)
  );

endmodule

`default_nettype wire
